// ===== src/gn3_pkg.sv =====
`default_nettype none

package gn3_pkg;

  localparam int TableSize = 256;
  localparam int FracBits  = 16;
  localparam int IdxW      = $clog2(TableSize);
  localparam int EntryW    = 8;
  localparam int CoordW    = 32;
  localparam int OutW      = 18;
  localparam int OutFrac   = 16;
  localparam int FadeW     = FracBits + 2;
  localparam int PolyW     = FracBits + 4;
  localparam int GradW     = FracBits + 4;
  localparam int One       = 1 << FracBits;
  localparam int OutMax    = (1 << (OutW - 1)) - 1;
  localparam int OutMin    = -(1 << (OutW - 1));
  localparam int ShR       = (FracBits > OutFrac) ? FracBits - OutFrac : 0;
  localparam int ShL       = (FracBits < OutFrac) ? OutFrac - FracBits : 0;

  typedef enum logic {
    OpLoad  = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef logic signed [GradW-1:0] grad_t;

  function automatic grad_t grad_dot(input logic [3:0] h, input grad_t x, input grad_t y,
                                     input grad_t z);
    grad_t gu;
    grad_t gv;
    grad_t su;
    grad_t sv;
    gu = (h < 4'd8) ? x : y;
    gv = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    su = h[0] ? -gu : gu;
    sv = h[1] ? -gv : gv;
    return su + sv;
  endfunction

  function automatic grad_t lerp_fx(input grad_t a, input grad_t b,
                                    input logic [FadeW-1:0] t);
    logic signed [GradW:0]         d;
    logic signed [GradW+FadeW+1:0] p;
    logic signed [GradW+FadeW+1:0] s;
    d = $signed({b[GradW-1], b}) - $signed({a[GradW-1], a});
    p = $signed({1'b0, t}) * d;
    s = p >>> FracBits;
    return a + GradW'(s);
  endfunction

endpackage

`default_nettype wire

// ===== src/gn3_if.sv =====
`default_nettype none

interface gn3_in_if import gn3_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [EntryW-1:0]        entry_index;
  logic [EntryW-1:0]        entry_value;
  logic signed [CoordW-1:0] coord_x;
  logic signed [CoordW-1:0] coord_y;
  logic signed [CoordW-1:0] coord_z;

  modport source (output valid, op, entry_index, entry_value, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, op, entry_index, entry_value, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface gn3_out_if import gn3_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

`default_nettype wire

// ===== src/gn3_ram.sv =====
`default_nettype none

module gn3_ram #(
  parameter int  Width = 8,
  parameter int  Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// ===== src/gn3_fade.sv =====
`default_nettype none

module gn3_fade import gn3_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [FracBits-1:0] t_i,
  output logic      [FadeW-1:0]    fade_o
);

  localparam int Pw = PolyW + 1;

  logic [2*FracBits-1:0]     sq;
  logic [2*FracBits-1:0]     cube;
  logic [Pw-1:0]             pos;
  logic [Pw-1:0]             neg;
  logic [FracBits+PolyW-1:0] prod;
  logic [FracBits-1:0]       t1_q;
  logic [FracBits-1:0]       t2_q;
  logic [FracBits-1:0]       t3_q;
  logic [PolyW-1:0]          poly_q;
  logic [FadeW-1:0]          fade_q;

  always_comb begin
    sq   = (2*FracBits)'(t_i) * (2*FracBits)'(t_i);
    cube = (2*FracBits)'(t2_q) * (2*FracBits)'(t1_q);
    pos  = Pw'(6) * Pw'(t2_q) + Pw'(10 * One);
    neg  = Pw'(15) * Pw'(t1_q);
    prod = (FracBits+PolyW)'(t3_q) * (FracBits+PolyW)'(poly_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q   <= t_i;
      t2_q   <= sq[2*FracBits-1:FracBits];
      t3_q   <= cube[2*FracBits-1:FracBits];
      poly_q <= (pos > neg) ? PolyW'(pos - neg) : '0;
      fade_q <= FadeW'(prod >> FracBits);
    end
  end

  assign fade_o = fade_q;

endmodule

`default_nettype wire

// ===== src/gradient_noise_3d.sv =====
// Channel  Role      Contents
// in_i     sink      op, entry_index, entry_value, coord_x, coord_y, coord_z
// out_o    source    noise_value, one per query, none per load
//
// One item is taken every cycle unless the output stalls.
// The depth is set by three chained permutation lookups, a three-multiply fade and three lerps.
// Loads write the table copies as they pass each lookup stage, so order is kept.
// Reset clears the valid bits only; the table is undefined until loaded.
// A stalled output freezes the whole pipeline, and in_i.ready follows it.
`default_nettype none

module gradient_noise_3d import gn3_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gn3_in_if.sink    in_i,
  gn3_out_if.source out_o
);

  logic en;
  logic out_vld_q;
  logic signed [OutW-1:0] noise_q;
  logic signed [OutW-1:0] noise_d;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  logic           in_load;
  logic           in_query;
  logic [IdxW-1:0] xi;
  assign in_load  = in_i.valid && (in_i.op == OpLoad);
  assign in_query = in_i.valid && (in_i.op == OpQuery);
  assign xi       = in_i.coord_x[FracBits+IdxW-1:FracBits];

  logic [FadeW-1:0] fu;
  logic [FadeW-1:0] fv;
  logic [FadeW-1:0] fw;

  gn3_fade u_fade_x (.clk_i(clk_i), .en_i(en), .t_i(in_i.coord_x[FracBits-1:0]), .fade_o(fu));
  gn3_fade u_fade_y (.clk_i(clk_i), .en_i(en), .t_i(in_i.coord_y[FracBits-1:0]), .fade_o(fv));
  gn3_fade u_fade_z (.clk_i(clk_i), .en_i(en), .t_i(in_i.coord_z[FracBits-1:0]), .fade_o(fw));

  // Stage 1.
  logic ld1_q, qv1_q;
  logic [IdxW-1:0]     y1_q, z1_q, ei1_q;
  logic [EntryW-1:0]   ev1_q;
  logic [FracBits-1:0] fx1_q, fy1_q, fz1_q;
  logic [EntryW-1:0]   p1a, p1b;

  gn3_ram #(.Width(EntryW), .Depth(TableSize)) u_ram_l1 (
    .clk_i, .we_i(en && in_load), .waddr_i(in_i.entry_index[IdxW-1:0]),
    .wdata_i(in_i.entry_value), .re_i(en), .raddr_a_i(xi), .raddr_b_i(xi + 1'b1),
    .rdata_a_o(p1a), .rdata_b_o(p1b)
  );

  logic [IdxW-1:0] ha, hb;
  assign ha = IdxW'(p1a) + y1_q;
  assign hb = IdxW'(p1b) + y1_q;

  // Stage 2.
  logic ld2_q, qv2_q;
  logic [IdxW-1:0]     z2_q, ei2_q;
  logic [EntryW-1:0]   ev2_q;
  logic [FracBits-1:0] fx2_q, fy2_q, fz2_q;
  logic [EntryW-1:0]   p2a0, p2a1, p2b0, p2b1;
  logic                we2;
  assign we2 = en && ld1_q;

  gn3_ram #(.Width(EntryW), .Depth(TableSize)) u_ram_l2a (
    .clk_i, .we_i(we2), .waddr_i(ei1_q), .wdata_i(ev1_q), .re_i(en),
    .raddr_a_i(ha), .raddr_b_i(ha + 1'b1), .rdata_a_o(p2a0), .rdata_b_o(p2a1)
  );
  gn3_ram #(.Width(EntryW), .Depth(TableSize)) u_ram_l2b (
    .clk_i, .we_i(we2), .waddr_i(ei1_q), .wdata_i(ev1_q), .re_i(en),
    .raddr_a_i(hb), .raddr_b_i(hb + 1'b1), .rdata_a_o(p2b0), .rdata_b_o(p2b1)
  );

  logic [IdxW-1:0] haa, hab, hba, hbb;
  assign haa = IdxW'(p2a0) + z2_q;
  assign hab = IdxW'(p2a1) + z2_q;
  assign hba = IdxW'(p2b0) + z2_q;
  assign hbb = IdxW'(p2b1) + z2_q;

  // Stage 3.
  logic qv3_q;
  logic [FracBits-1:0] fx3_q, fy3_q, fz3_q;
  logic [EntryW-1:0]   g_aa, g_aa1, g_ba, g_ba1, g_ab, g_ab1, g_bb, g_bb1;
  logic                we3;
  assign we3 = en && ld2_q;

  gn3_ram #(.Width(EntryW), .Depth(TableSize)) u_ram_l3aa (
    .clk_i, .we_i(we3), .waddr_i(ei2_q), .wdata_i(ev2_q), .re_i(en),
    .raddr_a_i(haa), .raddr_b_i(haa + 1'b1), .rdata_a_o(g_aa), .rdata_b_o(g_aa1)
  );
  gn3_ram #(.Width(EntryW), .Depth(TableSize)) u_ram_l3ba (
    .clk_i, .we_i(we3), .waddr_i(ei2_q), .wdata_i(ev2_q), .re_i(en),
    .raddr_a_i(hba), .raddr_b_i(hba + 1'b1), .rdata_a_o(g_ba), .rdata_b_o(g_ba1)
  );
  gn3_ram #(.Width(EntryW), .Depth(TableSize)) u_ram_l3ab (
    .clk_i, .we_i(we3), .waddr_i(ei2_q), .wdata_i(ev2_q), .re_i(en),
    .raddr_a_i(hab), .raddr_b_i(hab + 1'b1), .rdata_a_o(g_ab), .rdata_b_o(g_ab1)
  );
  gn3_ram #(.Width(EntryW), .Depth(TableSize)) u_ram_l3bb (
    .clk_i, .we_i(we3), .waddr_i(ei2_q), .wdata_i(ev2_q), .re_i(en),
    .raddr_a_i(hbb), .raddr_b_i(hbb + 1'b1), .rdata_a_o(g_bb), .rdata_b_o(g_bb1)
  );

  grad_t xp, xm, yp, ym, zp, zm;
  grad_t grad_d [8];
  always_comb begin
    xp = GradW'(fx3_q);
    yp = GradW'(fy3_q);
    zp = GradW'(fz3_q);
    xm = xp - GradW'(One);
    ym = yp - GradW'(One);
    zm = zp - GradW'(One);
    grad_d[0] = grad_dot(g_aa[3:0],  xp, yp, zp);
    grad_d[1] = grad_dot(g_ba[3:0],  xm, yp, zp);
    grad_d[2] = grad_dot(g_ab[3:0],  xp, ym, zp);
    grad_d[3] = grad_dot(g_bb[3:0],  xm, ym, zp);
    grad_d[4] = grad_dot(g_aa1[3:0], xp, yp, zm);
    grad_d[5] = grad_dot(g_ba1[3:0], xm, yp, zm);
    grad_d[6] = grad_dot(g_ab1[3:0], xp, ym, zm);
    grad_d[7] = grad_dot(g_bb1[3:0], xm, ym, zm);
  end

  // Stages 4 to 6: the lerp tree.
  logic qv4_q, qv5_q, qv6_q;
  grad_t grad_q [8];
  grad_t l_q [4];
  grad_t m_q [2];
  logic [FadeW-1:0] u4_q, v4_q, w4_q, v5_q, w5_q, w6_q;

  grad_t r6;
  logic signed [GradW+ShL-1:0] rw;
  always_comb begin
    r6 = lerp_fx(m_q[0], m_q[1], w6_q);
    rw = (GradW+ShL)'(r6 >>> ShR) <<< ShL;
    if (rw > OutMax) begin
      noise_d = OutW'(OutMax);
    end else if (rw < OutMin) begin
      noise_d = OutW'(OutMin);
    end else begin
      noise_d = OutW'(rw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld1_q     <= 1'b0;
      qv1_q     <= 1'b0;
      ld2_q     <= 1'b0;
      qv2_q     <= 1'b0;
      qv3_q     <= 1'b0;
      qv4_q     <= 1'b0;
      qv5_q     <= 1'b0;
      qv6_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      ld1_q     <= in_load;
      qv1_q     <= in_query;
      ld2_q     <= ld1_q;
      qv2_q     <= qv1_q;
      qv3_q     <= qv2_q;
      qv4_q     <= qv3_q;
      qv5_q     <= qv4_q;
      qv6_q     <= qv5_q;
      out_vld_q <= qv6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y1_q  <= in_i.coord_y[FracBits+IdxW-1:FracBits];
      z1_q  <= in_i.coord_z[FracBits+IdxW-1:FracBits];
      ei1_q <= in_i.entry_index[IdxW-1:0];
      ev1_q <= in_i.entry_value;
      fx1_q <= in_i.coord_x[FracBits-1:0];
      fy1_q <= in_i.coord_y[FracBits-1:0];
      fz1_q <= in_i.coord_z[FracBits-1:0];
      z2_q  <= z1_q;
      ei2_q <= ei1_q;
      ev2_q <= ev1_q;
      fx2_q <= fx1_q;
      fy2_q <= fy1_q;
      fz2_q <= fz1_q;
      fx3_q <= fx2_q;
      fy3_q <= fy2_q;
      fz3_q <= fz2_q;
      grad_q <= grad_d;
      u4_q  <= fu;
      v4_q  <= fv;
      w4_q  <= fw;
      l_q[0] <= lerp_fx(grad_q[0], grad_q[1], u4_q);
      l_q[1] <= lerp_fx(grad_q[2], grad_q[3], u4_q);
      l_q[2] <= lerp_fx(grad_q[4], grad_q[5], u4_q);
      l_q[3] <= lerp_fx(grad_q[6], grad_q[7], u4_q);
      v5_q  <= v4_q;
      w5_q  <= w4_q;
      m_q[0] <= lerp_fx(l_q[0], l_q[1], v5_q);
      m_q[1] <= lerp_fx(l_q[2], l_q[3], v5_q);
      w6_q  <= w5_q;
      noise_q <= noise_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.noise_value = noise_q;

endmodule

`default_nettype wire

// ===== src/gn3_checker.sv =====
`default_nettype none

module gn3_checker import gn3_pkg::*; (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_ready_i,
  input wire logic            out_valid_i,
  input wire logic            out_ready_i,
  input wire logic [OutW-1:0] noise_value_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(noise_value_i))
    else $error("Stalled result changed or vanished.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("Input refused while the output register is empty.");

  a_stall_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("Input taken while the pipeline is stalled.");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("Result shown during reset.");

endmodule

bind gradient_noise_3d gn3_checker u_gn3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .noise_value_i (out_o.noise_value)
);

`default_nettype wire
